### src/per_channel_scale_bias_with_gradients_defines.svh
// assertion macros for the per-channel scale and bias block
// expects clk_i and rst_ni in the scope of each use
`ifndef PER_CHANNEL_SCALE_BIAS_WITH_GRADIENTS_DEFINES_SVH
`define PER_CHANNEL_SCALE_BIAS_WITH_GRADIENTS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define PCSB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pcsb assertion failed");
// checked at every edge, reset included
`define PCSB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pcsb assertion failed");
`else
`define PCSB_ASSERT(lbl, prop)
`define PCSB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### src/pcsb_pkg.sv
// shared types and constants for the per-channel scale and bias block
// no dependencies
`default_nettype none

package pcsb_pkg;

  // sizing
  localparam int MaxChannels   = 256;
  localparam int DataBits      = 16;
  localparam int WordBits      = 16;
  localparam int SelBits       = 8;
  localparam int CountBits     = 9;
  localparam int CfgStrideBits = 21;
  localparam int StrideBits    = 20;
  localparam int StrideLimit   = 1 << StrideBits;
  localparam int CfgDataBits   = 21;
  localparam int CfgIndexBits  = 2;
  localparam int SaccBits      = 48;
  localparam int BaccBits      = 32;
  localparam int AccBits       = SaccBits + BaccBits;
  localparam int TabBits       = 2 * WordBits;
  localparam int FifoDepth     = 4;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeFwd  = 2'd1,
    ModeBwd  = 2'd2,
    ModeRead = 2'd3
  } mode_e;

  typedef enum logic [CfgIndexBits-1:0] {
    RegChannelCount  = 2'd0,
    RegChannelStride = 2'd1,
    RegUseBias       = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    mode_e                       mode;
    logic                        start_req;
    logic signed [WordBits-1:0]  data_value;
    logic signed [WordBits-1:0]  grad_value;
    logic        [SelBits-1:0]   channel_select;
    logic signed [WordBits-1:0]  scale_word;
    logic signed [WordBits-1:0]  bias_word;
  } in_item_t;

  typedef struct packed {
    logic signed [WordBits-1:0]  value;
    logic signed [SaccBits-1:0]  scale_grad;
    logic signed [BaccBits-1:0]  bias_grad;
    logic                        saturated;
  } out_item_t;

  typedef struct packed {
    logic [CfgIndexBits-1:0] index;
    logic [CfgDataBits-1:0]  value;
  } cfg_item_t;

  typedef struct packed {
    logic      push;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

### src/pcsb_stream_if.sv
// valid/ready channel carrying one item of a chosen type
// used by the top level and the output queue
`default_nettype none

interface pcsb_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/per_channel_scale_bias_with_gradients.sv
// a result passes the multiply and round/accumulate stages, then a four-entry queue
// throughput: one item per cycle while the queue has credit and no clearing sweep runs
// reset: config registers go to count 1, stride 1, bias on; the gradient accumulator
// ram is then cleared one entry a cycle, all MAX_CHANNELS entries, with input ready low,
// config writes are taken during that sweep
`default_nettype none
`include "per_channel_scale_bias_with_gradients_defines.svh"

module per_channel_scale_bias_with_gradients #(
  parameter int MAX_CHANNELS = pcsb_pkg::MaxChannels
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  pcsb_stream_if.sink    cfg_i,
  pcsb_stream_if.sink    in_i,
  pcsb_stream_if.source  out_o
);
  localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [pcsb_pkg::CountBits-1:0]     cfg_count_q;
  logic [pcsb_pkg::CfgStrideBits-1:0] cfg_stride_q;
  logic                               cfg_use_bias_q;

  logic                clr_busy_q;
  logic [ChW-1:0]      clr_ptr_q;

  logic                in_accept, credit;
  logic [ChW-1:0]      ch, sel_addr;
  logic                sel_ok;
  logic                tab_we;
  logic [pcsb_pkg::TabBits-1:0] tab_rdata;
  logic [pcsb_pkg::AccBits-1:0] acc_rdata, dp_acc_wdata, acc_wdata;
  logic [ChW-1:0]      dp_acc_waddr, acc_waddr, acc_raddr;
  logic                dp_acc_we, acc_we;
  pcsb_pkg::result_t   dp_res;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q    <= pcsb_pkg::CountBits'(1);
      cfg_stride_q   <= pcsb_pkg::CfgStrideBits'(1);
      cfg_use_bias_q <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (pcsb_pkg::cfg_reg_e'(cfg_i.data.index))
        pcsb_pkg::RegChannelCount:  cfg_count_q    <= cfg_i.data.value[pcsb_pkg::CountBits-1:0];
        pcsb_pkg::RegChannelStride: cfg_stride_q   <= cfg_i.data.value;
        pcsb_pkg::RegUseBias:       cfg_use_bias_q <= cfg_i.data.value[0];
        default: begin
        end
      endcase
    end
  end

  // accumulator clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_ptr_q  <= '0;
    end else if (clr_busy_q) begin
      if (32'(clr_ptr_q) == MAX_CHANNELS - 1) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_ptr_q <= clr_ptr_q + ChW'(1);
      end
    end
  end

  // input handshake
  assign in_i.ready = credit & ~clr_busy_q;
  assign in_accept  = in_i.valid & in_i.ready;

  pcsb_position #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_position (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .mode_i     (in_i.data.mode),
    .start_i    (in_i.data.start_req),
    .sel_i      (in_i.data.channel_select),
    .count_i    (cfg_count_q),
    .stride_i   (cfg_stride_q),
    .ch_o       (ch),
    .sel_ok_o   (sel_ok),
    .sel_addr_o (sel_addr)
  );

  // scale and bias table, written by load items
  assign tab_we = in_accept & (in_i.data.mode == pcsb_pkg::ModeLoad) & sel_ok;

  pcsb_ram #(
    .WIDTH (pcsb_pkg::TabBits),
    .DEPTH (MAX_CHANNELS)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (sel_addr),
    .wdata_i ({in_i.data.scale_word, in_i.data.bias_word}),
    .re_i    (in_accept),
    .raddr_i (ch),
    .rdata_o (tab_rdata)
  );

  // gradient accumulators, scale part above bias part
  assign acc_raddr = (in_i.data.mode == pcsb_pkg::ModeRead) ? sel_addr : ch;
  assign acc_we    = clr_busy_q | dp_acc_we;
  assign acc_waddr = clr_busy_q ? clr_ptr_q : dp_acc_waddr;
  assign acc_wdata = clr_busy_q ? '0 : dp_acc_wdata;

  pcsb_ram #(
    .WIDTH (pcsb_pkg::AccBits),
    .DEPTH (MAX_CHANNELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (in_accept),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  pcsb_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (in_i.data),
    .ch_i        (ch),
    .sel_ok_i    (sel_ok),
    .sel_addr_i  (sel_addr),
    .use_bias_i  (cfg_use_bias_q),
    .tab_rdata_i (tab_rdata),
    .acc_rdata_i (acc_rdata),
    .acc_we_o    (dp_acc_we),
    .acc_waddr_o (dp_acc_waddr),
    .acc_wdata_o (dp_acc_wdata),
    .res_o       (dp_res)
  );

  pcsb_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .credit_o (credit),
    .push_i   (dp_res.push),
    .item_i   (dp_res.item),
    .out_o    (out_o)
  );

  // the clearing sweep owns the accumulator write port
  `PCSB_ASSERT_ALWAYS(a_no_update_in_clear, !(clr_busy_q && dp_acc_we))
  // every result comes from an accepted item that passed the multiply and round stages
  `PCSB_ASSERT(a_push_after_accept, dp_res.push |-> $past(in_accept, 2))
  // accumulator updates only for accepted items that passed the multiply and round stages
  `PCSB_ASSERT(a_update_after_accept, dp_acc_we |-> $past(in_accept, 2))
endmodule

`default_nettype wire

### src/pcsb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pcsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AddrW-1:0]      waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AddrW-1:0]      raddr_i,
  output logic      [WIDTH-1:0]      rdata_o
);
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

`default_nettype wire

### src/pcsb_position.sv
// stride and channel position counters, channel of the current item
// depends on pcsb_pkg
`default_nettype none

module pcsb_position #(
  parameter int MAX_CHANNELS = pcsb_pkg::MaxChannels
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire pcsb_pkg::mode_e                     mode_i,
  input  wire logic                                start_i,
  input  wire logic [pcsb_pkg::SelBits-1:0]        sel_i,
  input  wire logic [pcsb_pkg::CountBits-1:0]      count_i,
  input  wire logic [pcsb_pkg::CfgStrideBits-1:0]  stride_i,
  output logic      [ChW-1:0]                      ch_o,
  output logic                                     sel_ok_o,
  output logic      [ChW-1:0]                      sel_addr_o
);
  localparam int ChW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CntW = $clog2(MAX_CHANNELS + 1);
  localparam int SW   = pcsb_pkg::StrideBits;

  logic [ChW-1:0]  cp_q, cp_d;
  logic [SW-1:0]   sp_q, sp_d;
  logic [CntW-1:0] cnt_eff;
  logic [SW:0]     str_eff;
  logic [ChW-1:0]  cp_cur;
  logic [SW-1:0]   sp_cur;
  logic [SW:0]     sp_inc;
  logic [ChW:0]    cp_inc;
  logic            streaming;

  // effective count and stride: zero means one, large values clip
  always_comb begin
    if (count_i == '0) begin
      cnt_eff = CntW'(1);
    end else if (32'(count_i) > MAX_CHANNELS) begin
      cnt_eff = CntW'(MAX_CHANNELS);
    end else begin
      cnt_eff = CntW'(count_i);
    end
    if (stride_i == '0) begin
      str_eff = (SW+1)'(1);
    end else if (32'(stride_i) > pcsb_pkg::StrideLimit) begin
      str_eff = (SW+1)'(pcsb_pkg::StrideLimit);
    end else begin
      str_eff = (SW+1)'(stride_i);
    end
  end

  // channel of this item and the positions after it
  always_comb begin
    cp_cur = start_i ? '0 : cp_q;
    sp_cur = start_i ? '0 : sp_q;
    ch_o   = (32'(cp_cur) >= 32'(cnt_eff)) ? '0 : cp_cur;
    sp_inc = {1'b0, sp_cur} + (SW+1)'(1);
    cp_inc = {1'b0, ch_o} + (ChW+1)'(1);
    if (sp_inc >= str_eff) begin
      sp_d = '0;
      cp_d = (32'(cp_inc) >= 32'(cnt_eff)) ? '0 : cp_inc[ChW-1:0];
    end else begin
      sp_d = sp_inc[SW-1:0];
      cp_d = ch_o;
    end
  end

  assign streaming  = (mode_i == pcsb_pkg::ModeFwd) || (mode_i == pcsb_pkg::ModeBwd);
  assign sel_ok_o   = 32'(sel_i) < MAX_CHANNELS;
  assign sel_addr_o = ChW'(sel_i);

  // load and read items only clear the counters on start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= '0;
      sp_q <= '0;
    end else if (accept_i) begin
      if (streaming) begin
        cp_q <= cp_d;
        sp_q <= sp_d;
      end else if (start_i) begin
        cp_q <= '0;
        sp_q <= '0;
      end
    end
  end
endmodule

`default_nettype wire

### src/pcsb_datapath.sv
// multiply stage and round/accumulate stage with accumulator forwarding
// depends on pcsb_pkg; table and accumulator rams sit in the top level
`default_nettype none

module pcsb_datapath #(
  parameter int MAX_CHANNELS = pcsb_pkg::MaxChannels
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire pcsb_pkg::in_item_t               item_i,
  input  wire logic [ChW-1:0]                   ch_i,
  input  wire logic                             sel_ok_i,
  input  wire logic [ChW-1:0]                   sel_addr_i,
  input  wire logic                             use_bias_i,
  input  wire logic [pcsb_pkg::TabBits-1:0]     tab_rdata_i,
  input  wire logic [pcsb_pkg::AccBits-1:0]     acc_rdata_i,
  output logic                                  acc_we_o,
  output logic      [ChW-1:0]                   acc_waddr_o,
  output logic      [pcsb_pkg::AccBits-1:0]     acc_wdata_o,
  output pcsb_pkg::result_t                     res_o
);
  localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WB  = pcsb_pkg::WordBits;
  localparam int SB  = pcsb_pkg::SaccBits;
  localparam int BB  = pcsb_pkg::BaccBits;
  localparam int AB  = pcsb_pkg::AccBits;
  localparam logic signed [33:0] ValMax =
    34'((64'sd1 <<< (pcsb_pkg::DataBits - 1)) - 64'sd1);
  localparam logic signed [33:0] ValMin = -ValMax - 34'sd1;
  localparam logic signed [SB:0] SaccMax = (SB+1)'((65'sd1 <<< (SB - 1)) - 65'sd1);
  localparam logic signed [SB:0] SaccMin = -SaccMax - (SB+1)'(1);
  localparam logic signed [BB:0] BaccMax = (BB+1)'((65'sd1 <<< (BB - 1)) - 65'sd1);
  localparam logic signed [BB:0] BaccMin = -BaccMax - (BB+1)'(1);

  // multiply stage registers
  logic                   b_valid_q;
  pcsb_pkg::mode_e        b_mode_q;
  logic [ChW-1:0]         b_addr_q;
  logic                   b_sel_ok_q;
  logic signed [WB-1:0]   b_data_q, b_grad_q;

  // round and accumulate stage registers
  logic                   c_valid_q;
  pcsb_pkg::mode_e        c_mode_q;
  logic [ChW-1:0]         c_addr_q;
  logic                   c_sel_ok_q;
  logic signed [31:0]     c_pval_q, c_pacc_q;
  logic signed [WB-1:0]   c_bias_q, c_grad_q;
  logic signed [SB-1:0]   c_sacc_q;
  logic signed [BB-1:0]   c_bacc_q;

  // last accumulator write, covers the read that raced it
  logic                   lw_valid_q;
  logic [ChW-1:0]         lw_addr_q;
  logic [AB-1:0]          lw_data_q;

  logic signed [WB-1:0]   scale, bias, mul_a;
  logic signed [31:0]     pval_d, pacc_d;
  logic signed [WB-1:0]   bias_d;
  logic [AB-1:0]          acc_fwd;

  logic signed [33:0]     sum, shf, val_cl;
  logic                   val_sat;
  logic signed [SB:0]     s_sum;
  logic signed [SB-1:0]   s_new;
  logic                   s_sat;
  logic signed [BB:0]     b_sum;
  logic signed [BB-1:0]   b_new;
  logic                   b_sat;
  logic                   c_we;
  logic [AB-1:0]          c_acc_new;
  pcsb_pkg::out_item_t    out_d;

  // item address: read mode uses the selected channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      b_mode_q   <= item_i.mode;
      b_addr_q   <= (item_i.mode == pcsb_pkg::ModeRead) ? sel_addr_i : ch_i;
      b_sel_ok_q <= sel_ok_i;
      b_data_q   <= item_i.data_value;
      b_grad_q   <= item_i.grad_value;
    end
  end

  // products and bias term
  always_comb begin
    scale  = tab_rdata_i[2*WB-1:WB];
    bias   = tab_rdata_i[WB-1:0];
    mul_a  = (b_mode_q == pcsb_pkg::ModeFwd) ? b_data_q : b_grad_q;
    pval_d = mul_a * scale;
    pacc_d = b_grad_q * b_data_q;
    bias_d = ((b_mode_q == pcsb_pkg::ModeFwd) && use_bias_i) ? bias : '0;
  end

  // accumulator operand: newest of stage c, last write, ram
  always_comb begin
    if (c_valid_q && c_we && (c_addr_q == b_addr_q)) begin
      acc_fwd = c_acc_new;
    end else if (lw_valid_q && (lw_addr_q == b_addr_q)) begin
      acc_fwd = lw_data_q;
    end else begin
      acc_fwd = acc_rdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      c_mode_q   <= b_mode_q;
      c_addr_q   <= b_addr_q;
      c_sel_ok_q <= b_sel_ok_q;
      c_pval_q   <= pval_d;
      c_pacc_q   <= pacc_d;
      c_bias_q   <= bias_d;
      c_grad_q   <= b_grad_q;
      c_sacc_q   <= acc_fwd[AB-1:BB];
      c_bacc_q   <= acc_fwd[BB-1:0];
    end
  end

  // round to nearest, ties up, then clamp to the data range
  always_comb begin
    sum     = 34'(c_pval_q) + (34'(c_bias_q) <<< 12) + 34'sd2048;
    shf     = sum >>> 12;
    val_sat = 1'b0;
    if (shf > ValMax) begin
      val_cl  = ValMax;
      val_sat = 1'b1;
    end else if (shf < ValMin) begin
      val_cl  = ValMin;
      val_sat = 1'b1;
    end else begin
      val_cl  = shf;
    end
  end

  // saturating accumulator updates
  always_comb begin
    s_sum = (SB+1)'(c_sacc_q) + (SB+1)'(c_pacc_q);
    s_sat = 1'b0;
    if (s_sum > SaccMax) begin
      s_new = SaccMax[SB-1:0];
      s_sat = 1'b1;
    end else if (s_sum < SaccMin) begin
      s_new = SaccMin[SB-1:0];
      s_sat = 1'b1;
    end else begin
      s_new = s_sum[SB-1:0];
    end
    b_sum = (BB+1)'(c_bacc_q) + (BB+1)'(c_grad_q);
    b_sat = 1'b0;
    if (b_sum > BaccMax) begin
      b_new = BaccMax[BB-1:0];
      b_sat = 1'b1;
    end else if (b_sum < BaccMin) begin
      b_new = BaccMin[BB-1:0];
      b_sat = 1'b1;
    end else begin
      b_new = b_sum[BB-1:0];
    end
  end

  // result item and write-back per mode
  always_comb begin
    out_d     = '0;
    c_we      = 1'b0;
    c_acc_new = '0;
    case (c_mode_q)
      pcsb_pkg::ModeFwd: begin
        out_d.value     = val_cl[WB-1:0];
        out_d.saturated = val_sat;
      end
      pcsb_pkg::ModeBwd: begin
        out_d.value     = val_cl[WB-1:0];
        out_d.saturated = val_sat | s_sat | (use_bias_i & b_sat);
        c_we            = 1'b1;
        c_acc_new       = {s_new, use_bias_i ? b_new : c_bacc_q};
      end
      pcsb_pkg::ModeRead: begin
        if (c_sel_ok_q) begin
          out_d.scale_grad = c_sacc_q;
          out_d.bias_grad  = c_bacc_q;
          c_we             = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign acc_we_o    = c_valid_q & c_we;
  assign acc_waddr_o = c_addr_q;
  assign acc_wdata_o = c_acc_new;
  assign res_o.push  = c_valid_q;
  assign res_o.item  = out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else begin
      lw_valid_q <= acc_we_o;
    end
  end

  always_ff @(posedge clk_i) begin
    lw_addr_q <= c_addr_q;
    lw_data_q <= c_acc_new;
  end
endmodule

`default_nettype wire

### src/pcsb_out_fifo.sv
// result queue with credit count over items in flight
// depends on pcsb_pkg and pcsb_stream_if
`default_nettype none

module pcsb_out_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  output logic                      credit_o,
  input  wire logic                 push_i,
  input  wire pcsb_pkg::out_item_t  item_i,
  pcsb_stream_if.source             out_o
);
  localparam int Depth = pcsb_pkg::FifoDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  pcsb_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q, flight_q;
  logic            pop;

  assign pop         = out_o.valid & out_o.ready;
  assign out_o.valid = fill_q != '0;
  assign out_o.data  = mem_q[rd_ptr_q];
  // an item is taken only if its result has a slot reserved
  assign credit_o    = 32'(flight_q) < Depth;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers wrap at the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      flight_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      fill_q   <= fill_q + CntW'(push_i) - CntW'(pop);
      flight_q <= flight_q + CntW'(accept_i) - CntW'(pop);
    end
  end
endmodule

`default_nettype wire

### sim/per_channel_scale_bias_with_gradients_tb.sv
`timescale 1ns / 1ps
// testbench for per_channel_scale_bias_with_gradients: directed and random items,
// each result checked against a behavioral predictor of the scale, bias and gradient math
// depends on pcsb_pkg, pcsb_stream_if and the block's rtl

module per_channel_scale_bias_with_gradients_tb;
  import pcsb_pkg::*;

  // scale accumulator reaches its limit after 2^17 items of 2^30 each
  localparam int SatItems   = 131073;
  localparam int PhaseItems = 120;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pcsb_stream_if #(.item_t(cfg_item_t)) cfg_if ();
  pcsb_stream_if #(.item_t(in_item_t))  in_if ();
  pcsb_stream_if #(.item_t(out_item_t)) out_if ();

  per_channel_scale_bias_with_gradients dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic signed [WordBits-1:0] scale_tab [MaxChannels];
  logic signed [WordBits-1:0] bias_tab  [MaxChannels];
  bit                         loaded    [MaxChannels];
  longint                     sgrad_acc [MaxChannels];
  longint                     bgrad_acc [MaxChannels];
  int                         elem_pos     = 0;
  int                         chan_pos     = 0;
  int                         cfg_count    = 1;
  int                         cfg_stride   = 1;
  bit                         cfg_use_bias = 1'b1;

  out_item_t expected_results [$];
  int        mismatch_count;
  int        in_idle_pct;
  int        out_stall_pct;
  logic      hold_results;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // channel count as the block uses it
  function automatic int eff_count();
    int c;
    c = (cfg_count == 0) ? 1 : cfg_count;
    return (c > MaxChannels) ? MaxChannels : c;
  endfunction

  function automatic longint clamp_sat(longint x, int bits, inout bit sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -(longint'(1) <<< (bits - 1));
    if (x > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (x < lo) begin
      sat = 1'b1;
      return lo;
    end
    return x;
  endfunction

  // q12.20 to q8.8, round half up, clamp to the data width
  function automatic longint round_q88(longint q1220, inout bit sat);
    return clamp_sat((q1220 + 2048) >>> 12, DataBits, sat);
  endfunction

  // channel that a forward or backward item will use
  function automatic int next_channel(in_item_t it);
    if (it.start_req) return 0;
    return (chan_pos >= eff_count()) ? 0 : chan_pos;
  endfunction

  // expected result of one item, advancing the predictor state
  function automatic out_item_t affine_step(in_item_t it);
    out_item_t r;
    bit        sat;
    int        cnt;
    int        str;
    int        ch;
    longint    grad;
    longint    data;
    longint    acc;
    r    = '0;
    sat  = 1'b0;
    cnt  = eff_count();
    str  = (cfg_stride == 0) ? 1 : cfg_stride;
    if (str > StrideLimit) str = StrideLimit;
    grad = longint'($signed(it.grad_value));
    data = longint'($signed(it.data_value));
    if (it.start_req) begin
      elem_pos = 0;
      chan_pos = 0;
    end
    case (it.mode)
      ModeLoad: begin
        scale_tab[it.channel_select] = it.scale_word;
        bias_tab[it.channel_select]  = it.bias_word;
        loaded[it.channel_select]    = 1'b1;
      end
      ModeRead: begin
        r.scale_grad = SaccBits'(sgrad_acc[it.channel_select]);
        r.bias_grad  = BaccBits'(bgrad_acc[it.channel_select]);
        sgrad_acc[it.channel_select] = 0;
        bgrad_acc[it.channel_select] = 0;
      end
      default: begin
        if (chan_pos >= cnt) chan_pos = 0;
        ch = chan_pos;
        if (it.mode == ModeFwd) begin
          acc = data * longint'(scale_tab[ch]);
          if (cfg_use_bias) acc += longint'(bias_tab[ch]) * 4096;
          r.value = WordBits'(round_q88(acc, sat));
        end else begin
          r.value = WordBits'(round_q88(grad * longint'(scale_tab[ch]), sat));
          sgrad_acc[ch] = clamp_sat(sgrad_acc[ch] + grad * data, SaccBits, sat);
          if (cfg_use_bias) bgrad_acc[ch] = clamp_sat(bgrad_acc[ch] + grad, BaccBits, sat);
        end
        // position counters
        elem_pos++;
        if (elem_pos >= str) begin
          elem_pos = 0;
          chan_pos++;
          if (chan_pos >= cnt) chan_pos = 0;
        end
      end
    endcase
    r.saturated = sat;
    return r;
  endfunction

  function automatic in_item_t make_item(mode_e m, bit st, logic [WordBits-1:0] d,
                                         logic [WordBits-1:0] g, logic [SelBits-1:0] sel,
                                         logic [WordBits-1:0] sw, logic [WordBits-1:0] bw);
    in_item_t it;
    it.mode           = m;
    it.start_req      = st;
    it.data_value     = d;
    it.grad_value     = g;
    it.channel_select = sel;
    it.scale_word     = sw;
    it.bias_word      = bw;
    return it;
  endfunction

  // word biased toward the extremes and small values
  function automatic logic [WordBits-1:0] rand_word();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return '1;
      4, 5:    return WordBits'($urandom_range(512) - 256);
      default: return WordBits'($urandom());
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       cnt;
    cnt  = eff_count();
    pick = $urandom_range(99);
    it.mode = (pick < 15) ? ModeLoad : (pick < 50) ? ModeFwd : (pick < 85) ? ModeBwd : ModeRead;
    it.start_req      = ($urandom_range(49) == 0);
    it.data_value     = rand_word();
    it.grad_value     = rand_word();
    it.channel_select = $urandom_range(1) ? SelBits'($urandom_range(cnt - 1))
                                          : SelBits'($urandom());
    it.scale_word     = rand_word();
    it.bias_word      = rand_word();
    // parameters of this channel never loaded: load them first
    if ((it.mode == ModeFwd || it.mode == ModeBwd) && !loaded[next_channel(it)]) begin
      it.channel_select = SelBits'(next_channel(it));
      it.mode           = ModeLoad;
    end
    return it;
  endfunction

  // offer one item, predict its result once accepted
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_results.push_back(affine_step(it));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataBits-1:0] v);
    cfg_item_t c;
    c.index = idx;
    c.value = v;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      RegChannelCount:  cfg_count    = int'(v[CountBits-1:0]);
      RegChannelStride: cfg_stride   = int'(v[CfgStrideBits-1:0]);
      RegUseBias:       cfg_use_bias = v[0];
      default: ;
    endcase
  endtask

  // all three registers, once the block is idle
  task automatic configure(logic [CfgDataBits-1:0] count, logic [CfgDataBits-1:0] stride,
                           logic [CfgDataBits-1:0] bias);
    wait_drained();
    write_reg(RegChannelCount, count);
    write_reg(RegChannelStride, stride);
    write_reg(RegUseBias, bias);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $error("result with no item pending: value %0d", got.value);
      mismatch_count++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("value", want.value, got.value);
    compare_field("scale_grad", want.scale_grad, got.scale_grad);
    compare_field("bias_grad", want.bias_grad, got.bias_grad);
    compare_field("saturated", want.saturated, got.saturated);
  endtask

  // result side: check accepted items, stall at random or during a hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      check_result(out_if.data);
    end
    out_if.ready <= !hold_results && ($urandom_range(99) >= out_stall_pct);
  end

  // full-scale parameters, products clamping both ways
  task automatic test_extremes();
    send_item(make_item(ModeLoad, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF));
    send_item(make_item(ModeLoad, 0, 0, 0, 1, 16'h8000, 16'h8000));
    send_item(make_item(ModeLoad, 0, 0, 0, 2, 16'h0800, 16'h0000));
    send_item(make_item(ModeLoad, 0, 0, 0, 3, 16'h1000, 16'h0100));
    send_item(make_item(ModeFwd, 1, 16'h7FFF, 0, 0, 0, 0));
    send_item(make_item(ModeFwd, 0, 16'h8000, 0, 0, 0, 0));
    send_item(make_item(ModeBwd, 0, 16'h8000, 16'h8000, 0, 0, 0));
    send_item(make_item(ModeBwd, 0, 16'h8000, 16'h7FFF, 0, 0, 0));
  endtask

  // half-lsb ties round toward +inf
  task automatic test_rounding();
    send_item(make_item(ModeFwd, 0, 16'h0001, 0, 0, 0, 0));
    send_item(make_item(ModeFwd, 0, 16'hFFFF, 0, 0, 0, 0));
    send_item(make_item(ModeBwd, 0, 16'h7FFF, 16'hFFFF, 0, 0, 0));
    send_item(make_item(ModeBwd, 0, 16'h8000, 16'h0001, 0, 0, 0));
  endtask

  // start in load and read modes resets the counters without advancing them
  task automatic test_start_flag();
    send_item(make_item(ModeFwd, 0, 16'h0100, 0, 0, 0, 0));
    send_item(make_item(ModeLoad, 1, 0, 0, 3, 16'h1000, 16'h0100));
    send_item(make_item(ModeFwd, 0, 16'h0100, 0, 0, 0, 0));
    send_item(make_item(ModeRead, 1, 0, 0, 3, 0, 0));
  endtask

  // counters left out of range by a smaller count or stride
  task automatic test_counter_bounds();
    configure(4, 1, 1);
    send_item(make_item(ModeFwd, 1, rand_word(), 0, 0, 0, 0));
    send_item(make_item(ModeFwd, 0, rand_word(), 0, 0, 0, 0));
    send_item(make_item(ModeFwd, 0, rand_word(), 0, 0, 0, 0));
    // channel 3 beyond a count of 2, zero stride taken as 1
    configure(2, 0, 1);
    send_item(make_item(ModeFwd, 0, rand_word(), 0, 0, 0, 0));
    configure(3, 3, 1);
    send_item(make_item(ModeFwd, 0, rand_word(), 0, 0, 0, 0));
    send_item(make_item(ModeFwd, 0, rand_word(), 0, 0, 0, 0));
    // stride position beyond the new stride wraps at its next advance
    configure(3, 2, 1);
    send_item(make_item(ModeFwd, 0, rand_word(), 0, 0, 0, 0));
    send_item(make_item(ModeFwd, 0, rand_word(), 0, 0, 0, 0));
  endtask

  // no bias added, bias accumulator untouched
  task automatic test_bias_disabled();
    configure(2, 1, 0);
    send_item(make_item(ModeBwd, 1, rand_word(), rand_word(), 0, 0, 0));
    send_item(make_item(ModeBwd, 0, rand_word(), rand_word(), 0, 0, 0));
    send_item(make_item(ModeFwd, 0, rand_word(), 0, 0, 0, 0));
    send_item(make_item(ModeRead, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ModeRead, 0, 0, 0, 8'hFF, 0, 0));
  endtask

  task automatic test_random_phases();
    int phase;
    int k;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
          configure(CfgDataBits'($urandom_range(2, 6)), CfgDataBits'($urandom_range(1, 3)), 1);
        end
        1: begin
          // count field all ones: clamps to every channel
          in_idle_pct   = 57;
          out_stall_pct = 0;
          configure('1, 1, 0);
        end
        2: begin
          // stride field all ones: clamps to the longest run
          in_idle_pct   = 0;
          out_stall_pct = 57;
          configure(CfgDataBits'($urandom_range(1, 5)), '1, 1);
        end
        default: begin
          in_idle_pct   = 6;
          out_stall_pct = 6;
          configure(0, CfgDataBits'($urandom_range(1, 4)), 1);
        end
      endcase
      for (k = 0; k < PhaseItems; k++) send_item(random_item());
    end
  endtask

  // long receiver hold-off fills the block, then the sender pauses for a drain
  task automatic test_result_backpressure();
    int k;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    configure(3, 2, 1);
    fork
      begin
        hold_results <= 1'b1;
        repeat (60) @(posedge clk_i);
        hold_results <= 1'b0;
      end
      begin
        for (k = 0; k < 40; k++) send_item(random_item());
      end
    join
    wait_drained();
    for (k = 0; k < 10; k++) send_item(random_item());
  endtask

  // 2^30 per item: bias accumulator clamps halfway, scale accumulator from item 2^17 on
  task automatic test_accumulator_saturation();
    int k;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    configure(1, 1, 1);
    send_item(make_item(ModeLoad, 0, 0, 0, 0, 16'h1000, 16'h0000));
    send_item(make_item(ModeRead, 1, 0, 0, 0, 0, 0));
    for (k = 0; k < SatItems; k++) begin
      send_item(make_item(ModeBwd, 0, 16'h8000, 16'h8000, 0, 0, 0));
    end
    send_item(make_item(ModeRead, 0, 0, 0, 0, 0, 0));
  endtask

  // main sequence
  initial begin
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    out_if.ready   = 1'b0;
    hold_results   = 1'b0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    mismatch_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // registers are taken while the accumulator ram is still being cleared
    configure(4, 2, 1);
    test_extremes();
    test_rounding();
    test_start_flag();
    test_counter_bounds();
    test_bias_disabled();
    test_random_phases();
    test_result_backpressure();
    test_accumulator_saturation();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/pcsb_pkg.sv
src/pcsb_stream_if.sv
src/pcsb_ram.sv
src/pcsb_position.sv
src/pcsb_datapath.sv
src/pcsb_out_fifo.sv
src/per_channel_scale_bias_with_gradients.sv
sim/per_channel_scale_bias_with_gradients_tb.sv
